FILE: rtl/ole_pkg.sv
// Shared types and constants for the ordered list engine.
`default_nettype none
package ole_pkg;
  localparam int CAPACITY = 64;
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);

  typedef enum logic [3:0] {
    OP_INS_FRONT  = 4'd0,
    OP_INS_BACK   = 4'd1,
    OP_INS_BEFORE = 4'd2,
    OP_INS_AFTER  = 4'd3,
    OP_DEL_FRONT  = 4'd4,
    OP_DEL_BACK   = 4'd5,
    OP_DEL_BEFORE = 4'd6,
    OP_DEL_AFTER  = 4'd7,
    OP_DEL_MATCH  = 4'd8,
    OP_CLEAR      = 4'd9,
    OP_SORT       = 4'd10,
    OP_READ       = 4'd11
  } op_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EMPTY    = 3'd1,
    ST_NOT_FOUND = 3'd2,
    ST_NO_NEIGH = 3'd3,
    ST_FULL     = 3'd4
  } status_t;
endpackage
`default_nettype wire

FILE: rtl/ordered_list_engine_top.sv
// Top level of the ordered list engine: list storage and its sequencer.
//
// The block holds an ordered list of up to CAPACITY signed 32-bit words in a
// simple dual-port memory. A request on the in_ channel carries an operation,
// a value to insert and a key to search for. Every request answers with one
// result on the out_ channel, except a read out of a non-empty list, which
// gives one result per element, the final one marked by out_last.
//
// All work is done by one sequencer: a key search reads one entry at a time
// (S_SRCH_RD, then S_SRCH_CHK), a gap is opened or closed by moving one entry
// at a time (read, then write), and the sort compares one pair of entries at
// a time in S_SORT_RA, S_SORT_RB and S_SORT_CMP, with S_SORT_SWB added when
// the pair is swapped. A read out reads each element (S_RD_RD) and then
// presents it (S_RD_OUT).
// in_ready is high only while the sequencer is idle; one request is in
// flight at a time.
//
// Results sit in an output register; while the receiver stalls, the sequencer
// simply waits with the result held. Reset clears the element count, so the
// list starts empty; the memory contents are not cleared and need not be.
`default_nettype none
module ordered_list_engine_top
  import ole_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [3:0]         in_operation,
  input  wire logic signed [31:0] in_new_value,
  input  wire logic signed [31:0] in_match_key,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [2:0]              out_status,
  output logic signed [31:0]      out_element,
  output logic [5:0]              out_position,
  output logic [6:0]              out_length,
  output logic                    out_last
);

  typedef enum logic [3:0] {
    S_IDLE, S_SRCH_RD, S_SRCH_CHK, S_OPEN_RD, S_OPEN_WR, S_CLOSE_RD,
    S_CLOSE_WR, S_SORT_RA, S_SORT_RB, S_SORT_CMP, S_SORT_SWB, S_RD_RD,
    S_RD_OUT, S_RESULT
  } state_t;

  logic [31:0]      mem [CAPACITY];
  logic [31:0]      rdata_r;
  logic [IDX_W-1:0] raddr;
  logic             mem_we;
  logic [IDX_W-1:0] waddr;
  logic [31:0]      wdata;

  state_t           state_r;
  logic [3:0]       op_r;
  logic [31:0]      val_r, key_r, a_r;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] i_r, j_r;
  logic [2:0]       st_r;

  always_ff @(posedge clk) begin
    if (mem_we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  // Signed compare of the outer element against the inner element.
  logic a_gt_b;
  assign a_gt_b = $signed(a_r) > $signed(rdata_r);

  always_comb begin
    raddr  = i_r[IDX_W-1:0];
    mem_we = 1'b0;
    waddr  = i_r[IDX_W-1:0];
    wdata  = rdata_r;
    unique case (state_r)
      S_SORT_RB: raddr = j_r[IDX_W-1:0];
      S_OPEN_RD: raddr = IDX_W'(i_r - 1'b1);
      S_CLOSE_RD: raddr = IDX_W'(i_r + 1'b1);
      S_OPEN_WR, S_CLOSE_WR: mem_we = 1'b1;
      S_SORT_CMP: begin
        mem_we = a_gt_b;
        wdata  = rdata_r;
      end
      S_SORT_SWB: begin
        mem_we = 1'b1;
        waddr  = j_r[IDX_W-1:0];
        wdata  = a_r;
      end
      default: ;
    endcase
    // Opening the last gap position writes the new value itself.
    if (state_r == S_OPEN_RD && i_r == j_r) begin
      mem_we = 1'b1;
      wdata  = val_r;
    end
  end

  assign in_ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      cnt_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      priority case (state_r)
        S_IDLE: if (in_valid) begin
          op_r  <= in_operation;
          val_r <= in_new_value;
          key_r <= in_match_key;
          i_r   <= '0;
          st_r  <= ST_OK;
          state_r <= S_RESULT;
          priority if (in_operation == OP_INS_FRONT ||
                       in_operation == OP_INS_BACK ||
                       in_operation == OP_INS_BEFORE ||
                       in_operation == OP_INS_AFTER) begin
            if (cnt_r >= CNT_W'(CAPACITY)) st_r <= ST_FULL;
            else if (in_operation == OP_INS_FRONT) begin
              i_r <= cnt_r; j_r <= '0; state_r <= S_OPEN_RD;
            end else if (in_operation == OP_INS_BACK) begin
              i_r <= cnt_r; j_r <= cnt_r; state_r <= S_OPEN_RD;
            end else if (cnt_r == '0) st_r <= ST_EMPTY;
            else state_r <= S_SRCH_RD;
          end else if (in_operation > OP_READ) begin
            st_r <= ST_OK;
          end else if (cnt_r == '0) begin
            st_r <= ST_EMPTY;
          end else if (in_operation == OP_DEL_FRONT) begin
            i_r <= '0; state_r <= S_CLOSE_RD;
          end else if (in_operation == OP_DEL_BACK) begin
            i_r <= CNT_W'(cnt_r - 1'b1); state_r <= S_CLOSE_RD;
          end else if (in_operation == OP_CLEAR) begin
            cnt_r <= '0;
          end else if (in_operation == OP_SORT) begin
            j_r <= CNT_W'(1); state_r <= S_SORT_RA;
          end else if (in_operation == OP_READ) begin
            state_r <= S_RD_RD;
          end else begin
            state_r <= S_SRCH_RD;
          end
        end
        S_SRCH_RD: state_r <= S_SRCH_CHK;
        S_SRCH_CHK: begin
          if (rdata_r == key_r) begin
            unique case (op_r)
              OP_INS_BEFORE: begin j_r <= i_r; i_r <= cnt_r; state_r <= S_OPEN_RD; end
              OP_INS_AFTER: begin
                j_r <= CNT_W'(i_r + 1'b1); i_r <= cnt_r; state_r <= S_OPEN_RD;
              end
              OP_DEL_BEFORE: begin
                if (i_r == '0) begin st_r <= ST_NO_NEIGH; state_r <= S_RESULT; end
                else begin i_r <= CNT_W'(i_r - 1'b1); state_r <= S_CLOSE_RD; end
              end
              OP_DEL_AFTER: begin
                if (CNT_W'(i_r + 1'b1) >= cnt_r) begin
                  st_r <= ST_NO_NEIGH; state_r <= S_RESULT;
                end else begin i_r <= CNT_W'(i_r + 1'b1); state_r <= S_CLOSE_RD; end
              end
              default: state_r <= S_CLOSE_RD;
            endcase
          end else if (CNT_W'(i_r + 1'b1) >= cnt_r) begin
            st_r <= ST_NOT_FOUND; state_r <= S_RESULT;
          end else begin
            i_r <= CNT_W'(i_r + 1'b1); state_r <= S_SRCH_RD;
          end
        end
        // Walk from the end down to the gap, moving each entry up by one.
        S_OPEN_RD: begin
          if (i_r == j_r) begin
            cnt_r <= CNT_W'(cnt_r + 1'b1); state_r <= S_RESULT;
          end else state_r <= S_OPEN_WR;
        end
        S_OPEN_WR: begin i_r <= CNT_W'(i_r - 1'b1); state_r <= S_OPEN_RD; end
        S_CLOSE_RD: begin
          if (CNT_W'(i_r + 1'b1) >= cnt_r) begin
            cnt_r <= CNT_W'(cnt_r - 1'b1); state_r <= S_RESULT;
          end else state_r <= S_CLOSE_WR;
        end
        S_CLOSE_WR: begin i_r <= CNT_W'(i_r + 1'b1); state_r <= S_CLOSE_RD; end
        S_SORT_RA: begin
          if (CNT_W'(i_r + 1'b1) >= cnt_r) state_r <= S_RESULT;
          else if (j_r >= cnt_r) begin
            i_r <= CNT_W'(i_r + 1'b1); j_r <= CNT_W'(i_r + 2'd2);
          end else state_r <= S_SORT_RB;
        end
        S_SORT_RB: begin a_r <= rdata_r; state_r <= S_SORT_CMP; end
        S_SORT_CMP: state_r <= a_gt_b ? S_SORT_SWB : S_SORT_RA;
        S_SORT_SWB: begin j_r <= CNT_W'(j_r + 1'b1); state_r <= S_SORT_RA; end
        S_RD_RD: state_r <= S_RD_OUT;
        S_RD_OUT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_status   <= ST_OK;
            out_element  <= rdata_r;
            out_position <= 6'(i_r);
            out_length   <= 7'(cnt_r);
            out_last     <= (CNT_W'(i_r + 1'b1) == cnt_r);
            if (CNT_W'(i_r + 1'b1) == cnt_r) state_r <= S_IDLE;
            else begin i_r <= CNT_W'(i_r + 1'b1); state_r <= S_RD_RD; end
          end
        end
        S_RESULT: begin
          if (!out_valid || out_ready) begin
            out_valid    <= 1'b1;
            out_status   <= st_r;
            out_element  <= '0;
            out_position <= '0;
            out_length   <= 7'(cnt_r);
            out_last     <= 1'b1;
            state_r      <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
      // A pair in order needs no swap, so the inner index moves on at once.
      if (state_r == S_SORT_CMP && !a_gt_b) j_r <= CNT_W'(j_r + 1'b1);
      if (out_valid && out_ready &&
          !((state_r == S_RESULT) || (state_r == S_RD_OUT))) out_valid <= 1'b0;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/ole_checker.sv
// Port-level checker for the ordered list engine, bound to the top level.
`default_nettype none
module ole_port_checker
  import ole_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] out_status,
  input wire logic [6:0] out_length,
  input wire logic       out_last
);
  a_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_length <= 7'(CAPACITY)) else $error("length above capacity");
  a_stat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= ST_FULL) else $error("bad status code");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_last))
    else $error("result dropped while stalled");
  a_nack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != ST_OK |-> out_last)
    else $error("error result not final");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second request taken while busy");
endmodule

bind ordered_list_engine_top ole_port_checker u_ole_port_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
  .out_valid(out_valid), .out_ready(out_ready), .out_status(out_status),
  .out_length(out_length), .out_last(out_last)
);
`default_nettype wire
